FILE: hw/rtl/dsrw_pkg.sv
// Shared types, codes and constants of the DAC stream register writer.
// Used by every module but the sample store; depends on nothing.
`default_nettype none

package dsrw_pkg;

	// item opcodes
	localparam logic [2:0] OP_SETUP = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_LOAD  = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	// configuration register index
	localparam logic REG_OUTPUT_RATE = 1'b0;

	localparam int DEF_NUM_STREAMS = 4;
	localparam int DEF_NUM_BLOCKS  = 4;

	localparam int POS_W       = 14;
	localparam int BLOCK_DEPTH = 1 << POS_W;
	localparam int ACC_W       = 22;
	localparam int RATE_W      = 18;
	localparam int LEN_W       = 32;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
	localparam logic [ACC_W-1:0]  ACC_MAX    = '1;

	localparam int MAX_WRITES    = 64;
	localparam int STREAM_WRITES = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_TEST,
		ST_EMIT,
		ST_DONE
	} seq_state_t;

	typedef enum logic {
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic [ACC_W-1:0] result;
		logic             ge;
		logic             ge2;
	} acc_res_t;

	typedef struct packed {
		logic [7:0] chip;
		logic [7:0] port;
		logic [7:0] regno;
		logic [7:0] data;
	} write_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsrw_sample_mem.sv
// Byte store holding the sample data blocks: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module dsrw_sample_mem #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [7:0]        rd_data
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dsrw_acc_unit.sv
// Shared accumulator unit: one adder for the saturating credit add and the rate subtract.
// Depends on dsrw_pkg.
`default_nettype none

module dsrw_acc_unit
	import dsrw_pkg::*;
(
	input  wire acc_op_t           op,
	input  wire logic [ACC_W-1:0]  a,
	input  wire logic [ACC_W-1:0]  b,
	input  wire logic [RATE_W-1:0] rate,
	output acc_res_t               res
);

	logic [ACC_W-1:0] rate_ext;
	logic [ACC_W-1:0] addend;
	logic             cin;
	logic [ACC_W:0]   sum;
	logic [ACC_W:0]   rate2;

	always_comb begin
		rate_ext = ACC_W'(rate);
		rate2    = (ACC_W+1)'({rate, 1'b0});
		unique case (op)
			ACC_ADD: begin
				addend = b;
				cin    = 1'b0;
			end
			ACC_SUB: begin
				// a - rate as a + ~rate + 1; carry out means no borrow
				addend = ~rate_ext;
				cin    = 1'b1;
			end
		endcase
		sum = {1'b0, a} + {1'b0, addend} + (ACC_W+1)'(cin);
		res.result = (op == ACC_ADD && sum[ACC_W]) ? ACC_MAX : sum[ACC_W-1:0];
		res.ge     = sum[ACC_W];
		res.ge2    = {1'b0, a} >= rate2;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dsrw_sequencer.sv
// Stream table and tick sequencer: takes items, walks the streams on a tick and
// emits register writes. Depends on dsrw_pkg; drives dsrw_acc_unit and dsrw_sample_mem.
`default_nettype none

module dsrw_sequencer
	import dsrw_pkg::*;
#(
	parameter int NUM_STREAMS = DEF_NUM_STREAMS,
	parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
	parameter int ADDR_W      = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        opcode,
	input  wire logic [1:0]        stream_id,
	input  wire logic [7:0]        chip_id,
	input  wire logic [7:0]        port,
	input  wire logic [7:0]        reg_req,
	input  wire logic [1:0]        block_id,
	input  wire logic [POS_W-1:0]  start_offset,
	input  wire logic [LEN_W-1:0]  length,
	input  wire logic [ACC_W-1:0]  freq,
	input  wire logic [POS_W-1:0]  load_addr,
	input  wire logic [7:0]        load_byte,
	input  wire logic [RATE_W-1:0] rate,
	output acc_op_t                acc_op,
	output logic      [ACC_W-1:0]  acc_a,
	output logic      [ACC_W-1:0]  acc_b,
	input  wire acc_res_t          acc_res,
	output logic                   mem_wr_en,
	output logic      [ADDR_W-1:0] mem_wr_addr,
	output logic      [7:0]        mem_wr_data,
	output logic                   mem_rd_en,
	output logic      [ADDR_W-1:0] mem_rd_addr,
	input  wire logic [7:0]        mem_rd_data,
	output write_t                 res,
	output logic                   res_last,
	output logic                   res_strobe
);

	localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int NW = $clog2(MAX_WRITES + 1);
	localparam int KW = $clog2(STREAM_WRITES + 1);

	function automatic logic [BW-1:0] blk_mod(input logic [1:0] b);
		logic [4:0] v;
		v = 5'(b);
		for (int i = 0; i < 4; i++) begin
			if (v >= 5'(NUM_BLOCKS)) begin
				v = v - 5'(NUM_BLOCKS);
			end
		end
		return BW'(v);
	endfunction

	seq_state_t state_q, state_d;

	logic [SW-1:0] s_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [ACC_W-1:0] acc_q;

	logic [7:0]       st_chip_q   [NUM_STREAMS];
	logic [7:0]       st_port_q   [NUM_STREAMS];
	logic [7:0]       st_reg_q    [NUM_STREAMS];
	logic [BW-1:0]    st_blk_q    [NUM_STREAMS];
	logic             st_active_q [NUM_STREAMS];
	logic [POS_W-1:0] st_pos_q    [NUM_STREAMS];
	logic [LEN_W-1:0] st_rem_q    [NUM_STREAMS];
	logic [ACC_W-1:0] st_freq_q   [NUM_STREAMS];
	logic [ACC_W-1:0] st_accum_q  [NUM_STREAMS];

	write_t pend_q;
	logic   pend_valid_q;
	write_t res_q;
	logic   res_last_q;
	logic   res_strobe_q;

	logic             accept;
	logic [4:0]       sid_ext;
	logic             sid_ok;
	logic [SW-1:0]    sid;
	logic [BW-1:0]    blk_sel;
	logic [ACC_W-1:0] rate_ext;
	logic [ACC_W-1:0] fmax;
	logic [ACC_W-1:0] freq_sat;
	logic             last_s;
	logic             test_go;
	logic             emit_go;
	logic             rem_end;
	logic [POS_W-1:0] next_pos;

	logic             cur_active;
	logic [BW-1:0]    cur_blk;
	logic [POS_W-1:0] cur_pos;
	logic [LEN_W-1:0] cur_rem;

	always_comb begin
		busy     = (state_q != ST_IDLE);
		accept   = start && !busy;
		sid_ext  = 5'(stream_id);
		sid_ok   = sid_ext < 5'(NUM_STREAMS);
		sid      = sid_ext[SW-1:0];
		blk_sel  = blk_mod(block_id);
		rate_ext = ACC_W'(rate);
		fmax     = (rate_ext << 4) - rate_ext;
		freq_sat = (freq > fmax) ? fmax : freq;

		cur_active = st_active_q[s_q];
		cur_blk    = st_blk_q[s_q];
		cur_pos    = st_pos_q[s_q];
		cur_rem    = st_rem_q[s_q];
		next_pos   = cur_pos + 1'b1;

		last_s  = (s_q == SW'(NUM_STREAMS - 1));
		rem_end = (cur_rem == LEN_W'(1));
		test_go = acc_res.ge && (n_q != NW'(MAX_WRITES));
		// acc >= 2*rate means credit is left after this write
		emit_go = acc_res.ge2 && (k_q != KW'(STREAM_WRITES - 1))
			&& (n_q != NW'(MAX_WRITES - 1)) && !rem_end;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_TICK) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (cur_active) begin
					state_d = ST_TEST;
				end else if (last_s) begin
					state_d = ST_DONE;
				end
			end
			ST_TEST: begin
				if (test_go) begin
					state_d = ST_EMIT;
				end else if (last_s) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_EMIT: begin
				if (!emit_go) begin
					state_d = last_s ? ST_DONE : ST_SUM;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		acc_op      = (state_q == ST_SUM) ? ACC_ADD : ACC_SUB;
		acc_a       = (state_q == ST_SUM) ? st_accum_q[s_q] : acc_q;
		acc_b       = st_freq_q[s_q];
		mem_rd_en   = (state_q == ST_TEST && test_go) || (state_q == ST_EMIT && emit_go);
		mem_rd_addr = {cur_blk, (state_q == ST_EMIT) ? next_pos : cur_pos};
		mem_wr_en   = accept && (opcode == OP_LOAD);
		mem_wr_addr = {blk_sel, load_addr};
		mem_wr_data = load_byte;
		res         = res_q;
		res_last    = res_last_q;
		res_strobe  = res_strobe_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			s_q          <= '0;
			n_q          <= '0;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
			res_strobe_q <= 1'b0;
			res_last_q   <= 1'b0;
			for (int i = 0; i < NUM_STREAMS; i++) begin
				st_chip_q[i]   <= '0;
				st_port_q[i]   <= '0;
				st_reg_q[i]    <= '0;
				st_blk_q[i]    <= '0;
				st_active_q[i] <= 1'b0;
			end
		end else begin
			state_q      <= state_d;
			res_strobe_q <= 1'b0;
			res_last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_SETUP: begin
								if (sid_ok) begin
									st_chip_q[sid]   <= chip_id;
									st_port_q[sid]   <= port;
									st_reg_q[sid]    <= reg_req;
									st_blk_q[sid]    <= blk_sel;
									st_active_q[sid] <= 1'b0;
								end
							end
							OP_START: begin
								if (sid_ok) begin
									st_active_q[sid] <= 1'b1;
								end
							end
							OP_STOP: begin
								if (sid_ok) begin
									st_active_q[sid] <= 1'b0;
								end
							end
							OP_TICK: begin
								s_q <= '0;
								n_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SUM: begin
					k_q <= '0;
					if (!cur_active && !last_s) begin
						s_q <= SW'(s_q + 1'b1);
					end
				end
				ST_TEST: begin
					if (!test_go && !last_s) begin
						s_q <= SW'(s_q + 1'b1);
					end
				end
				ST_EMIT: begin
					n_q <= NW'(n_q + 1'b1);
					k_q <= KW'(k_q + 1'b1);
					if (rem_end) begin
						st_active_q[s_q] <= 1'b0;
					end
					if (!emit_go && !last_s) begin
						s_q <= SW'(s_q + 1'b1);
					end
					// hold each write until the next one shows whether it ends the tick
					res_strobe_q <= pend_valid_q;
					pend_valid_q <= 1'b1;
				end
				ST_DONE: begin
					res_strobe_q <= pend_valid_q;
					res_last_q   <= pend_valid_q;
					pend_valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_START && sid_ok) begin
					st_pos_q[sid]   <= start_offset;
					st_rem_q[sid]   <= length;
					st_freq_q[sid]  <= freq_sat;
					st_accum_q[sid] <= rate_ext;
				end
			end
			ST_SUM: begin
				acc_q <= acc_res.result;
			end
			ST_TEST: begin
				if (!test_go) begin
					st_accum_q[s_q] <= acc_q;
				end
			end
			ST_EMIT: begin
				acc_q         <= acc_res.result;
				st_pos_q[s_q] <= next_pos;
				st_rem_q[s_q] <= cur_rem - 1'b1;
				if (!emit_go) begin
					st_accum_q[s_q] <= acc_res.result;
				end
				pend_q.chip  <= st_chip_q[s_q];
				pend_q.port  <= st_port_q[s_q];
				pend_q.regno <= st_reg_q[s_q];
				pend_q.data  <= mem_rd_data;
				res_q        <= pend_q;
			end
			ST_DONE: begin
				res_q <= pend_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dac_stream_register_writer.sv
// Top level of the DAC stream register writer: APB rate register, sequencer,
// accumulator unit and sample store. Depends on dsrw_pkg and the dsrw_* modules.
//
// Usage: drive an item on opcode and the field ports and raise start; the item
// transfers at a clock edge with start high and busy low. Setup, start, stop and
// load-byte items finish in the transfer cycle, so busy stays low. A sample tick
// raises busy while the sequencer visits each stream in order: an idle stream is
// passed over in the sum state; an active one adds its frequency in the sum state
// and tests its credit in the test state, then gives its register writes in the
// emit state; a closing done state ends the tick. A tick gives at most 64
// writes; its pace is set by the single accumulator unit and the one read port
// of the store.
// Each write appears on out_* for one cycle with result_strobe high. A write is
// held until the next write step of the tick, or the closing cycle for the final
// one, and shows in the cycle after it; last marks the final write of the tick,
// which shows in the first cycle after busy falls. The receiver cannot stall.
// The user must write the output_rate register (address 0) only while idle; the
// block does not enforce it. Reset clears each stream's setup and active flag,
// sets output_rate to 44100 and leaves the sample store undefined until loaded.
`default_nettype none

module dac_stream_register_writer
	import dsrw_pkg::*;
#(
	parameter int NUM_STREAMS = DEF_NUM_STREAMS,
	parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         opcode,
	input  wire logic [1:0]         stream_id,
	input  wire logic [7:0]         chip_id,
	input  wire logic [7:0]         port,
	input  wire logic [7:0]         reg_req,
	input  wire logic [1:0]         block_id,
	input  wire logic [POS_W-1:0]   start_offset,
	input  wire logic [LEN_W-1:0]   length,
	input  wire logic [ACC_W-1:0]   freq,
	input  wire logic [POS_W-1:0]   load_addr,
	input  wire logic [7:0]         load_byte,
	output logic                    result_strobe,
	output logic      [7:0]         out_chip,
	output logic      [7:0]         out_port,
	output logic      [7:0]         out_reg,
	output logic      [7:0]         out_data,
	output logic                    last
);

	localparam int BW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int ADDR_W = BW + POS_W;
	localparam int DEPTH  = NUM_BLOCKS * BLOCK_DEPTH;

	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] rate_eff;
	logic              cfg_wr;

	acc_op_t           acc_op;
	logic [ACC_W-1:0]  acc_a;
	logic [ACC_W-1:0]  acc_b;
	acc_res_t          acc_res;

	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [7:0]        mem_wr_data;
	logic              mem_rd_en;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [7:0]        mem_rd_data;

	write_t            res;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign prdata   = (paddr[2] == REG_OUTPUT_RATE) ? 32'(rate_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_wr && paddr[2] == REG_OUTPUT_RATE) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	dsrw_acc_unit u_acc (
		.op   (acc_op),
		.a    (acc_a),
		.b    (acc_b),
		.rate (rate_eff),
		.res  (acc_res)
	);

	dsrw_sample_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	dsrw_sequencer #(
		.NUM_STREAMS (NUM_STREAMS),
		.NUM_BLOCKS  (NUM_BLOCKS),
		.ADDR_W      (ADDR_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.stream_id    (stream_id),
		.chip_id      (chip_id),
		.port         (port),
		.reg_req      (reg_req),
		.block_id     (block_id),
		.start_offset (start_offset),
		.length       (length),
		.freq         (freq),
		.load_addr    (load_addr),
		.load_byte    (load_byte),
		.rate         (rate_eff),
		.acc_op       (acc_op),
		.acc_a        (acc_a),
		.acc_b        (acc_b),
		.acc_res      (acc_res),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data),
		.res          (res),
		.res_last     (last),
		.res_strobe   (result_strobe)
	);

	assign out_chip = res.chip;
	assign out_port = res.port;
	assign out_reg  = res.regno;
	assign out_data = res.data;

	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> result_strobe)
		else $error("last flag without a result transfer");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_TICK) |=> busy)
		else $error("tick transfer did not start the sequencer");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result transfer right after the last write of a tick");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for dac_stream_register_writer: directed stream cases, then
// random command traffic under sender idling, checked against an in-bench stream model.
// Depends on dsrw_pkg and the dac_stream_register_writer RTL.

module tb_top;
	import dsrw_pkg::*;

	localparam int NS = DEF_NUM_STREAMS;
	localparam int SETTLE_CYCLES = 2 * NS + 72;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

	typedef struct {
		logic [2:0]       op;
		logic [1:0]       sid;
		logic [7:0]       chip;
		logic [7:0]       prt;
		logic [7:0]       regn;
		logic [1:0]       blk;
		logic [POS_W-1:0] offs;
		logic [LEN_W-1:0] len;
		logic [ACC_W-1:0] frq;
		logic [POS_W-1:0] laddr;
		logic [7:0]       lbyte;
	} stream_cmd_t;

	typedef struct {
		logic [7:0] chip;
		logic [7:0] port;
		logic [7:0] regno;
		logic [7:0] data;
		logic       last;
	} chip_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [2:0] opcode = '0;
	logic [1:0] stream_id = '0;
	logic [7:0] chip_id = '0;
	logic [7:0] port = '0;
	logic [7:0] reg_req = '0;
	logic [1:0] block_id = '0;
	logic [POS_W-1:0] start_offset = '0;
	logic [LEN_W-1:0] length = '0;
	logic [ACC_W-1:0] freq = '0;
	logic [POS_W-1:0] load_addr = '0;
	logic [7:0] load_byte = '0;
	logic result_strobe;
	logic [7:0] out_chip;
	logic [7:0] out_port;
	logic [7:0] out_reg;
	logic [7:0] out_data;
	logic last;

	dac_stream_register_writer DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .opcode(opcode), .stream_id(stream_id),
		.chip_id(chip_id), .port(port), .reg_req(reg_req), .block_id(block_id),
		.start_offset(start_offset), .length(length), .freq(freq),
		.load_addr(load_addr), .load_byte(load_byte),
		.result_strobe(result_strobe), .out_chip(out_chip), .out_port(out_port),
		.out_reg(out_reg), .out_data(out_data), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// stream table and sample store as the block should hold them
	logic [RATE_W-1:0] out_rate = RATE_RESET;
	logic [7:0] tgt_chip [0:NS-1] = '{default: '0};
	logic [7:0] tgt_port [0:NS-1] = '{default: '0};
	logic [7:0] tgt_reg [0:NS-1] = '{default: '0};
	logic [1:0] src_block [0:NS-1] = '{default: '0};
	bit playing [0:NS-1] = '{default: 1'b0};
	logic [POS_W-1:0] play_pos [0:NS-1] = '{default: '0};
	logic [LEN_W-1:0] bytes_left [0:NS-1] = '{default: '0};
	logic [ACC_W-1:0] step_freq [0:NS-1] = '{default: '0};
	logic [ACC_W-1:0] credit [0:NS-1] = '{default: '0};
	logic [7:0] sample_mem [0:65535];
	bit sample_set [0:65535];

	chip_write_t pending_writes [$];
	chip_write_t want;
	int bad_writes = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;
	int sent_items = 0;

	function automatic int eff_rate();
		return (out_rate == 0) ? 1 : int'(out_rate);
	endfunction

	// Play one sample tick. With commit clear the table is left as it is; either way
	// the address of the first unwritten sample that the tick would read is returned.
	function automatic int play_tick(input bit commit);
		int hole;
		int rate;
		int total;
		int k;
		int acc;
		int acc_cap;
		logic [15:0] addr;
		logic [POS_W-1:0] pos [0:NS-1];
		logic [LEN_W-1:0] left [0:NS-1];
		bit act [0:NS-1];
		logic [ACC_W-1:0] crd [0:NS-1];
		chip_write_t w;
		chip_write_t burst [$];
		hole = -1;
		rate = eff_rate();
		total = 0;
		acc_cap = ACC_MAX;
		pos = play_pos;
		left = bytes_left;
		act = playing;
		crd = credit;
		for (int s = 0; s < NS; s++) begin
			if (!act[s])
				continue;
			acc = crd[s] + step_freq[s];
			if (acc > acc_cap)
				acc = acc_cap;
			k = 0;
			while (acc >= rate && k < STREAM_WRITES && total < MAX_WRITES) begin
				addr = {src_block[s], pos[s]};
				if (!sample_set[addr] && hole < 0)
					hole = addr;
				w.chip = tgt_chip[s];
				w.port = tgt_port[s];
				w.regno = tgt_reg[s];
				w.data = sample_mem[addr];
				w.last = 1'b0;
				burst.push_back(w);
				total++;
				k++;
				pos[s] = pos[s] + 1'b1;
				acc -= rate;
				left[s] = left[s] - 1'b1;
				if (left[s] == 0) begin
					act[s] = 1'b0;
					break;
				end
			end
			crd[s] = acc[ACC_W-1:0];
		end
		if (commit) begin
			play_pos = pos;
			bytes_left = left;
			playing = act;
			credit = crd;
			if (burst.size() > 0)
				burst[burst.size()-1].last = 1'b1;
			foreach (burst[i])
				pending_writes.push_back(burst[i]);
		end
		return hole;
	endfunction

	function automatic void apply_cmd(input stream_cmd_t c);
		int fmax;
		fmax = 15 * eff_rate();
		case (c.op)
			OP_SETUP: begin
				tgt_chip[c.sid] = c.chip;
				tgt_port[c.sid] = c.prt;
				tgt_reg[c.sid] = c.regn;
				src_block[c.sid] = c.blk;
				playing[c.sid] = 1'b0;
			end
			OP_START: begin
				play_pos[c.sid] = c.offs;
				bytes_left[c.sid] = c.len;
				step_freq[c.sid] = (c.frq > fmax) ? ACC_W'(fmax) : c.frq;
				credit[c.sid] = ACC_W'(eff_rate());
				playing[c.sid] = 1'b1;
			end
			OP_STOP: begin
				playing[c.sid] = 1'b0;
			end
			OP_LOAD: begin
				sample_mem[{c.blk, c.laddr}] = c.lbyte;
				sample_set[{c.blk, c.laddr}] = 1'b1;
			end
			OP_TICK: begin
				void'(play_tick(1'b1));
			end
			default: begin
			end
		endcase
	endfunction

	// random fields but op and sid, so that fields an opcode does not use still toggle
	function automatic stream_cmd_t blank_cmd(input logic [2:0] op, input logic [1:0] sid);
		stream_cmd_t c;
		c.op = op;
		c.sid = sid;
		c.chip = $urandom;
		c.prt = $urandom;
		c.regn = $urandom;
		c.blk = $urandom;
		c.offs = $urandom;
		c.len = $urandom;
		c.frq = $urandom;
		c.laddr = $urandom;
		c.lbyte = $urandom;
		return c;
	endfunction

	function automatic stream_cmd_t random_cmd();
		stream_cmd_t c;
		int pick;
		c = blank_cmd(OP_TICK, 2'($urandom));
		pick = $urandom_range(99);
		if (pick < 40)
			c.op = OP_TICK;
		else if (pick < 55)
			c.op = OP_START;
		else if (pick < 65)
			c.op = OP_SETUP;
		else if (pick < 71)
			c.op = OP_STOP;
		else if (pick < 96)
			c.op = OP_LOAD;
		else
			c.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		if (c.op == OP_START) begin
			case ($urandom_range(9))
				0: c.len = '0;
				1: c.len = '1;
				2: ;
				default: c.len = $urandom_range(1, 48);
			endcase
			if ($urandom_range(9) != 0)
				c.frq = $urandom_range(0, 3 * eff_rate());
		end
		return c;
	endfunction

	// hold the item until a transfer takes it
	task automatic send_cmd(input stream_cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= c.op;
		stream_id <= c.sid;
		chip_id <= c.chip;
		port <= c.prt;
		reg_req <= c.regn;
		block_id <= c.blk;
		start_offset <= c.offs;
		length <= c.len;
		freq <= c.frq;
		load_addr <= c.laddr;
		load_byte <= c.lbyte;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_cmd(c);
		sent_items++;
	endtask

	// load every sample that the coming tick would read before it was written
	task automatic fill_missing_samples();
		int hole;
		stream_cmd_t c;
		hole = play_tick(1'b0);
		while (hole >= 0) begin
			c = blank_cmd(OP_LOAD, 2'($urandom));
			c.blk = hole[15:14];
			c.laddr = hole[13:0];
			send_cmd(c);
			hole = play_tick(1'b0);
		end
	endtask

	task automatic do_tick();
		fill_missing_samples();
		send_cmd(blank_cmd(OP_TICK, 2'($urandom)));
	endtask

	task automatic do_setup(input logic [1:0] sid, input logic [7:0] chip,
			input logic [7:0] prt, input logic [7:0] regn, input logic [1:0] blk);
		stream_cmd_t c;
		c = blank_cmd(OP_SETUP, sid);
		c.chip = chip;
		c.prt = prt;
		c.regn = regn;
		c.blk = blk;
		send_cmd(c);
	endtask

	task automatic do_start(input logic [1:0] sid, input logic [POS_W-1:0] offs,
			input logic [LEN_W-1:0] len, input logic [ACC_W-1:0] frq);
		stream_cmd_t c;
		c = blank_cmd(OP_START, sid);
		c.offs = offs;
		c.len = len;
		c.frq = frq;
		send_cmd(c);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0)
			@(posedge clk);
	endtask

	// drain, then let a tick that writes nothing run out before touching the register
	task automatic drain_and_settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_rate(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OUTPUT_RATE, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		out_rate = value[RATE_W-1:0];
	endtask

	// reset rate; a short stream that wraps at the block end and runs out mid-tick
	task automatic test_reset_rate();
		do_setup(2'd0, 8'hFF, 8'h00, 8'hAA, 2'd3);
		do_start(2'd0, 14'h3FFF, 32'd3, 22'd100000);
		do_tick();
	endtask

	task automatic test_stream_cases();
		stream_cmd_t c;
		drain_and_settle();
		write_rate(32'd10);
		do_setup(2'd1, 8'h00, 8'hFF, 8'h55, 2'd0);
		do_setup(2'd2, 8'h5A, 8'hA5, 8'hFF, 2'd1);
		do_setup(2'd3, 8'hC3, 8'h3C, 8'h00, 2'd2);
		// saturated frequency with zero length: full per-stream budget, plays on
		do_start(2'd1, 14'h0000, 32'd0, 22'h3FFFFF);
		// zero frequency: the preset credit gives one write, then the length runs out
		do_start(2'd2, 14'h2AAA, 32'd1, 22'd0);
		do_start(2'd3, 14'h1555, 32'd40, 22'd25);
		do_tick();
		do_tick();
		send_cmd(blank_cmd(OP_STOP, 2'd1));
		for (int u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++)
			send_cmd(blank_cmd(3'(u), 2'(u)));
		do_tick();
		// setup stops a running stream
		do_setup(2'd3, 8'h81, 8'h18, 8'h7E, 2'd2);
		do_tick();
		c = blank_cmd(OP_LOAD, 2'd0);
		c.blk = 2'd3;
		c.laddr = '1;
		c.lbyte = 8'hFF;
		send_cmd(c);
		c.blk = 2'd0;
		c.laddr = '0;
		c.lbyte = 8'h00;
		send_cmd(c);
	endtask

	// a frequency set at a high rate floods the accumulator once the rate drops
	task automatic test_rate_change();
		drain_and_settle();
		write_rate(32'hFFFF_FFFF);
		do_start(2'd0, 14'h0100, 32'd0, 22'h3FFFFF);
		do_tick();
		drain_and_settle();
		write_rate(32'd0);
		repeat (3)
			do_tick();
		send_cmd(blank_cmd(OP_STOP, 2'd0));
	endtask

	// count every transfer, sample loads included
	task automatic test_random_traffic(input int idle, input logic [31:0] rate_word,
			input int count);
		int first;
		bit paused;
		stream_cmd_t c;
		drain_and_settle();
		write_rate(rate_word);
		idle_pct = idle;
		first = sent_items;
		paused = 1'b0;
		while (sent_items - first < count) begin
			c = random_cmd();
			if (c.op == OP_TICK)
				fill_missing_samples();
			send_cmd(c);
			if (!paused && sent_items - first >= count / 2) begin
				paused = 1'b1;
				wait_for_results();
			end else if ($urandom_range(99) < 4) begin
				wait_for_results();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (pending_writes.size() == 0) begin
				bad_writes++;
				if (bad_writes <= 10)
					$display("unexpected write: chip %h port %h reg %h data %h last %b",
						out_chip, out_port, out_reg, out_data, last);
			end else begin
				want = pending_writes.pop_front();
				if (want.chip !== out_chip || want.port !== out_port ||
						want.regno !== out_reg || want.data !== out_data ||
						want.last !== last) begin
					bad_writes++;
					if (bad_writes <= 10) begin
						$display("write mismatch: want chip %h port %h reg %h data %h last %b",
							want.chip, want.port, want.regno, want.data, want.last);
						$display("                got  chip %h port %h reg %h data %h last %b",
							out_chip, out_port, out_reg, out_data, last);
					end
				end
			end
		end
	end

	// count cycles with no transfer of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("dac_stream_register_writer verification failed");
		$finish;
	end

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_rate();
		test_stream_cases();
		test_rate_change();
		test_random_traffic(22, 32'($urandom_range(1, 192000)), 55);
		test_random_traffic(68, 32'd192000, 55);
		test_random_traffic(0, 32'd1, 55);
		drain_and_settle();
		if (bad_writes == 0 && pending_writes.size() == 0)
			$display("dac_stream_register_writer verification clean");
		else
			$display("dac_stream_register_writer verification failed");
		$finish;
	end

endmodule

FILE: dac_stream_register_writer.f
hw/rtl/dsrw_pkg.sv
hw/rtl/dsrw_sample_mem.sv
hw/rtl/dsrw_acc_unit.sv
hw/rtl/dsrw_sequencer.sv
hw/rtl/dac_stream_register_writer.sv
tb/tb_top.sv
